// ===== rtl/core/ttrc_pkg.sv =====
`default_nettype none

package ttrc_pkg;

  localparam logic [15:0] CK_MOD       = 16'hFFFF;
  localparam logic [7:0]  FIRST_OFFSET = 8'd7;
  localparam logic [7:0]  ALPHA_STEP   = 8'd17;
  localparam logic [7:0]  BETA_STEP    = 8'd31;
  localparam logic [15:0] OLDER_INIT   = 16'd1;

  // end-around fold of a 25-bit magnitude into 0..65534
  function automatic logic [15:0] fold_mod(input logic [24:0] v);
    logic [16:0] s;
    s = 17'(v[24:16]) + 17'(v[15:0]);
    if (s >= 17'(CK_MOD)) begin
      s = s - 17'(CK_MOD);
    end
    return s[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/three_term_recurrence_checksum.sv =====
`default_nettype none

// channel   | ports                                   | dir
// ----------+-----------------------------------------+-----
// input     | in_valid in_ready in_data_byte in_last_byte | in
// result    | out_valid out_ready out_checksum        | out
//
// one byte is taken per cycle while in_ready is high; the term update (two narrow multiplies,
// subtract, modulo-65535 fold) finishes within the accepting cycle
// a checksum appears on out_* in the cycle after the transfer of the last byte
// input stalls only while an untaken checksum sits in the output register
// reset returns the terms to their initial values (older 1, newer 0) and clears position, message flag and output valid

module three_term_recurrence_checksum
  import ttrc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_checksum
);

  logic [15:0] older_r, older_nxt;
  logic [15:0] newer_r, newer_nxt;
  logic [7:0]  pos_r, pos_nxt;
  logic        in_msg_r, in_msg_nxt;
  logic        out_valid_r;
  logic [15:0] out_checksum_r;

  logic        in_fire;
  logic [7:0]  alpha;
  logic [7:0]  beta;
  logic [8:0]  factor;
  logic [24:0] pos_prod;
  logic [24:0] neg_prod;
  logic        pos_ge;
  logic [24:0] mag;
  logic [15:0] mag_fold;
  logic [15:0] term_next;
  logic [15:0] step_term;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // multipliers for this position
  assign alpha  = 8'(16'(pos_r) * 16'(ALPHA_STEP));
  assign beta   = 8'(16'(pos_r) * 16'(BETA_STEP));
  assign factor = 9'(in_data_byte) + 9'(alpha);

  assign pos_prod = 25'(factor) * 25'(newer_r);
  assign neg_prod = 25'(24'(beta) * 24'(older_r));
  assign pos_ge   = pos_prod >= neg_prod;
  assign mag      = pos_ge ? (pos_prod - neg_prod) : (neg_prod - pos_prod);
  assign mag_fold = fold_mod(mag);

  // negative difference wraps as (x + 1) mod 65535
  always_comb begin
    if (pos_ge) begin
      term_next = mag_fold;
    end else if (mag_fold <= 16'd1) begin
      term_next = {15'd0, ~mag_fold[0]};
    end else begin
      term_next = 16'(17'h10000 - 17'(mag_fold));
    end
  end

  always_comb begin
    older_nxt  = older_r;
    newer_nxt  = newer_r;
    pos_nxt    = pos_r;
    in_msg_nxt = in_msg_r;
    step_term  = newer_r;
    if (in_fire) begin
      if (!in_msg_r) begin
        step_term = 16'(in_data_byte) + 16'(FIRST_OFFSET);
        older_nxt = OLDER_INIT;
        pos_nxt   = 8'd1;
      end else begin
        step_term = term_next;
        older_nxt = newer_r;
        pos_nxt   = pos_r + 8'd1;
      end
      newer_nxt  = step_term;
      in_msg_nxt = 1'b1;
      if (in_last_byte) begin
        older_nxt  = OLDER_INIT;
        newer_nxt  = 16'd0;
        pos_nxt    = 8'd0;
        in_msg_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r     <= OLDER_INIT;
      newer_r     <= 16'd0;
      pos_r       <= 8'd0;
      in_msg_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      older_r  <= older_nxt;
      newer_r  <= newer_nxt;
      pos_r    <= pos_nxt;
      in_msg_r <= in_msg_nxt;
      if (in_fire && in_last_byte) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      out_checksum_r <= step_term;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_checksum = out_checksum_r;

  a_rise_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_fire && in_last_byte))
    else $error("checksum valid without last byte transfer");

  a_rearm : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_byte |=> !in_msg_r && pos_r == 8'd0)
    else $error("state not re-armed after last byte");

  a_idle_pos : assert property (@(posedge clk) disable iff (!rst_n)
    !in_msg_r |-> pos_r == 8'd0 && older_r == OLDER_INIT)
    else $error("idle state not at reset values");

  a_residue : assert property (@(posedge clk) disable iff (!rst_n)
    in_msg_r && pos_r != 8'd1 |-> newer_r != CK_MOD)
    else $error("term outside residue range");

endmodule

`default_nettype wire

// ===== bench/ttrc_checker.sv =====
`timescale 1ns / 100ps

module ttrc_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_checksum,
  output int          fail_count,
  output int          pending,
  output int          sums_seen,
  output int          neg_folds,
  output int          wraps
);

  localparam int unsigned MODULUS      = 65535;
  localparam logic [15:0] SEED_OLDER   = 16'd1;
  localparam logic [7:0]  START_OFFSET = 8'd7;
  localparam logic [7:0]  ALPHA_INC    = 8'd17;
  localparam logic [7:0]  BETA_INC     = 8'd31;
  localparam logic [7:0]  LAST_POS     = 8'hFF;

  logic [15:0] older_t;
  logic [15:0] newer_t;
  logic [7:0]  pos;
  logic        started;
  logic [15:0] sum_q[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] checksum mismatch: %s", $realtime, msg);
    fail_count = fail_count + 1;
  endtask

  // one recurrence step at the current position
  function automatic logic [15:0] next_term(input logic [7:0] b);
    logic [7:0]  alpha;
    logic [7:0]  beta;
    int unsigned gain;
    int unsigned drag;
    int unsigned d;
    alpha = pos * ALPHA_INC;
    beta  = pos * BETA_INC;
    gain  = (32'(b) + 32'(alpha)) * 32'(newer_t);
    drag  = 32'(beta) * 32'(older_t);
    if (gain >= drag) begin
      return 16'((gain - drag) % MODULUS);
    end
    // negative difference wraps through 2^64, which is 1 mod 65535
    neg_folds = neg_folds + 1;
    d = (drag - gain) % MODULUS;
    return 16'((MODULUS + 1 - d) % MODULUS);
  endfunction

  always @(posedge clk) begin
    logic [15:0] want;
    logic [15:0] nt;
    if (!rst_n) begin
      older_t = SEED_OLDER;
      newer_t = '0;
      pos     = '0;
      started = 1'b0;
      sum_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (sum_q.size() == 0) begin
          report_mismatch($sformatf("transfer of %h with nothing expected", out_checksum));
        end else begin
          want = sum_q.pop_front();
          sums_seen = sums_seen + 1;
          if (out_checksum !== want) begin
            report_mismatch($sformatf("got %h, expected %h", out_checksum, want));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (!started) begin
          older_t = SEED_OLDER;
          newer_t = 16'(in_data_byte) + 16'(START_OFFSET);
          pos     = 8'd1;
          started = 1'b1;
        end else begin
          nt = next_term(in_data_byte);
          if (pos == LAST_POS) begin
            wraps = wraps + 1;
          end
          older_t = newer_t;
          newer_t = nt;
          pos     = pos + 8'd1;
        end
        if (in_last_byte) begin
          sum_q.push_back(newer_t);
          older_t = SEED_OLDER;
          newer_t = '0;
          pos     = '0;
          started = 1'b0;
        end
      end
    end
    pending <= sum_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam int HALF_PERIOD   = 4;
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_BYTES   = 460;
  localparam int BURST_BYTES   = 40;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_checksum;

  int   fail_count;
  int   pending;
  int   sums_seen;
  int   neg_folds;
  int   wraps;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  logic hold_req = 1'b0;
  int   bytes_sent = 0;
  int   msgs_sent = 0;
  int   quiet_cycles = 0;

  always #(HALF_PERIOD) clk = ~clk;

  three_term_recurrence_checksum dut (.*);

  ttrc_checker chk (.*);

  task automatic send_byte(input logic [7:0] b, input logic lst);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= lst;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    bytes_sent++;
    if (lst) begin
      msgs_sent++;
    end
  endtask

  task automatic send_message(input int len);
    for (int k = 0; k < len; k++) begin
      send_byte(8'($urandom_range(255)), k == len - 1);
    end
  endtask

  // mostly short messages, now and then one long enough to wrap the position
  task automatic random_traffic(input int upto);
    while (bytes_sent < upto) begin
      if ($urandom_range(19) == 0) begin
        send_message($urandom_range(300, 257));
      end else begin
        send_message($urandom_range(16, 1));
      end
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    tx_idle_pct = 36;
    rx_idle_pct = 87;

    // single-byte messages at both extremes, then short multi-byte messages
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b1);
    for (int k = 0; k < 8; k++) begin
      send_byte((k % 2 == 0) ? 8'h00 : 8'hFF, k == 7);
    end
    send_byte(8'h80, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h7F, 1'b1);

    random_traffic(PHASE_BYTES);
    drain();

    tx_idle_pct = 87;
    rx_idle_pct = 36;
    random_traffic(2 * PHASE_BYTES);
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_req = 1'b1;
    send_message(BURST_BYTES);
    random_traffic(3 * PHASE_BYTES);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d bytes in %0d messages, %0d checksums compared",
             bytes_sent, msgs_sent, sums_seen);
    $display("negative folds seen: %0d, position wraps: %0d", neg_folds, wraps);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
